// ===== rtl/ctat_pkg.sv =====
package ctat_pkg;

    // Width of the byte position counter and of the held token start.
    localparam int unsigned POS_W = 32;
    // Width of the start and length fields on the result channel.
    localparam int unsigned OUT_W = 32;

    // Character codes the scanner looks for
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_OPEN   = 3'd1,
        KIND_CLOSE  = 3'd2,
        KIND_COMMA  = 3'd3,
        KIND_END    = 3'd4,
        KIND_IDENT  = 3'd5,
        KIND_NUMBER = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [OUT_W-1:0]  start;
        logic [OUT_W-1:0]  length;
        logic              last;
    } token_t;

    // Up to two tokens produced by one text byte, packed from slot 0.
    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } token_pair_t;

endpackage

// ===== rtl/ctat_scan.sv =====
module ctat_scan (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 fire,
    input  logic [7:0]           text_byte,
    output ctat_pkg::token_pair_t tokens
);

    typedef enum logic [6:0] {
        MODE_IDLE       = 7'b0000001,
        MODE_IDENT      = 7'b0000010,
        MODE_NUMBER     = 7'b0000100,
        MODE_SLASH      = 7'b0001000,
        MODE_LINE       = 7'b0010000,
        MODE_BLOCK      = 7'b0100000,
        MODE_BLOCK_STAR = 7'b1000000
    } mode_t;

    localparam logic [ctat_pkg::POS_W-1:0] POS_MAX = '1;

    mode_t                        mode_reg, mode_next;
    logic [ctat_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [ctat_pkg::POS_W-1:0]   pstart_reg, pstart_next;
    logic [ctat_pkg::POS_W-1:0]   held_len;

    logic            is_space, is_alpha, is_digit, is_word;
    logic            flush, idle_go, idle_emit, ended;
    ctat_pkg::token_t flush_tok, idle_tok;

    // Character classes
    always_comb begin
        is_space = (text_byte == ctat_pkg::CH_SPACE) || (text_byte == ctat_pkg::CH_TAB)
                || (text_byte == ctat_pkg::CH_LF) || (text_byte == ctat_pkg::CH_VT)
                || (text_byte == ctat_pkg::CH_FF) || (text_byte == ctat_pkg::CH_CR);
        is_alpha = ((text_byte >= 8'h61) && (text_byte <= 8'h7A))
                || ((text_byte >= 8'h41) && (text_byte <= 8'h5A));
        is_digit = (text_byte >= 8'h30) && (text_byte <= 8'h39);
        is_word  = is_alpha || is_digit || (text_byte == ctat_pkg::CH_UNDER);
    end

    assign held_len = pos_reg - pstart_reg;

    // Mode transitions; a held token closes first, then the byte is handled fresh
    always_comb begin
        mode_next   = mode_reg;
        pstart_next = pstart_reg;
        flush       = 1'b0;
        idle_go     = 1'b0;
        idle_emit   = 1'b0;
        ended       = 1'b0;
        flush_tok   = '{kind: ctat_pkg::KIND_NONE, start: '0, length: '0, last: 1'b0};
        idle_tok    = '{kind: ctat_pkg::KIND_NONE, start: '0, length: '0, last: 1'b0};

        unique case (mode_reg)
            MODE_IDENT: begin
                if (!is_word) begin
                    flush     = 1'b1;
                    flush_tok = '{kind: ctat_pkg::KIND_IDENT,
                                  start: ctat_pkg::OUT_W'(pstart_reg),
                                  length: ctat_pkg::OUT_W'(held_len), last: 1'b0};
                    idle_go   = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (!is_digit) begin
                    flush     = 1'b1;
                    flush_tok = '{kind: ctat_pkg::KIND_NUMBER,
                                  start: ctat_pkg::OUT_W'(pstart_reg),
                                  length: ctat_pkg::OUT_W'(held_len), last: 1'b0};
                    idle_go   = 1'b1;
                end
            end
            MODE_SLASH: begin
                if (text_byte == ctat_pkg::CH_SLASH) begin
                    mode_next = MODE_LINE;
                end else if (text_byte == ctat_pkg::CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end else begin
                    flush   = 1'b1;  // lone slash: kind none
                    idle_go = 1'b1;
                end
            end
            MODE_LINE: begin
                if (text_byte == ctat_pkg::CH_NUL) begin
                    idle_go = 1'b1;
                end else if ((text_byte == ctat_pkg::CH_LF)
                          || (text_byte == ctat_pkg::CH_CR)) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_BLOCK: begin
                if (text_byte == ctat_pkg::CH_NUL) begin
                    idle_go = 1'b1;
                end else if (text_byte == ctat_pkg::CH_STAR) begin
                    mode_next = MODE_BLOCK_STAR;
                end
            end
            MODE_BLOCK_STAR: begin
                if (text_byte == ctat_pkg::CH_NUL) begin
                    idle_go = 1'b1;
                end else if (text_byte == ctat_pkg::CH_SLASH) begin
                    mode_next = MODE_IDLE;
                end else if (text_byte != ctat_pkg::CH_STAR) begin
                    mode_next = MODE_BLOCK;
                end
            end
            default: begin
                idle_go = 1'b1;
            end
        endcase

        // Byte handled with no token held
        if (idle_go) begin
            if (text_byte == ctat_pkg::CH_NUL) begin
                ended     = 1'b1;
                idle_emit = 1'b1;
                idle_tok  = '{kind: ctat_pkg::KIND_END, start: ctat_pkg::OUT_W'(pos_reg),
                              length: ctat_pkg::OUT_W'(1), last: 1'b0};
            end else if (is_space) begin
                mode_next = MODE_IDLE;
            end else if (text_byte == ctat_pkg::CH_SLASH) begin
                mode_next   = MODE_SLASH;
                pstart_next = pos_reg;
            end else if (is_alpha) begin
                mode_next   = MODE_IDENT;
                pstart_next = pos_reg;
            end else if (is_digit) begin
                mode_next   = MODE_NUMBER;
                pstart_next = pos_reg;
            end else begin
                mode_next = MODE_IDLE;
                idle_emit = 1'b1;
                if (text_byte == ctat_pkg::CH_LPAREN) begin
                    idle_tok = '{kind: ctat_pkg::KIND_OPEN, start: ctat_pkg::OUT_W'(pos_reg),
                                 length: ctat_pkg::OUT_W'(1), last: 1'b0};
                end else if (text_byte == ctat_pkg::CH_RPAREN) begin
                    idle_tok = '{kind: ctat_pkg::KIND_CLOSE, start: ctat_pkg::OUT_W'(pos_reg),
                                 length: ctat_pkg::OUT_W'(1), last: 1'b0};
                end else if (text_byte == ctat_pkg::CH_COMMA) begin
                    idle_tok = '{kind: ctat_pkg::KIND_COMMA, start: ctat_pkg::OUT_W'(pos_reg),
                                 length: ctat_pkg::OUT_W'(1), last: 1'b0};
                end
            end
        end

        // End of text restarts the scan; otherwise the position saturates
        if (ended) begin
            mode_next   = MODE_IDLE;
            pos_next    = '0;
            pstart_next = '0;
        end else if (pos_reg != POS_MAX) begin
            pos_next = pos_reg + ctat_pkg::POS_W'(1);
        end else begin
            pos_next = pos_reg;
        end
    end

    // Pack the tokens from slot 0 and mark the final one
    always_comb begin
        tokens.count = {1'b0, flush} + {1'b0, idle_emit};
        tokens.tok1  = idle_tok;
        if (flush) begin
            tokens.tok0      = flush_tok;
            tokens.tok0.last = !idle_emit;
        end else begin
            tokens.tok0      = idle_tok;
            tokens.tok0.last = 1'b1;
        end
        tokens.tok1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            pos_reg    <= '0;
            pstart_reg <= '0;
        end else if (fire) begin
            mode_reg   <= mode_next;
            pos_reg    <= pos_next;
            pstart_reg <= pstart_next;
        end
    end

endmodule

// ===== rtl/ctat_tokq.sv =====
module ctat_tokq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ctat_pkg::token_pair_t tokens,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output ctat_pkg::token_t      out_tok
);

    // Four-entry token queue; a write stores up to two tokens at once.
    ctat_pkg::token_t entry_reg [4];
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic [2:0] cnt_after_pop;
    logic [1:0] push_n;
    logic       pop;

    assign out_valid     = (cnt_reg != 3'd0);
    assign out_tok       = entry_reg[rd_ptr_reg];
    assign pop           = out_valid && out_ready;
    assign cnt_after_pop = cnt_reg - {2'b00, pop};
    // Space for a full pair after this cycle's pop
    assign room          = (cnt_after_pop <= 3'd2);
    assign push_n        = push ? tokens.count : 2'd0;

    always_comb begin
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        wr_ptr_next = wr_ptr_reg + push_n;
        cnt_next    = cnt_after_pop + {1'b0, push_n};
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= tokens.tok0;
        end
        if (push_n == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= tokens.tok1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/c_comment_aware_tokenizer_top.sv =====
// Tokenizer for C-like text that skips whitespace and comments.
// Input channel (s_valid/s_ready/s_text_byte): one text byte per transfer;
// a zero byte ends the text and emits an end token.
// Result channel (m_valid/m_ready/m_token_*): tokens with kind, start
// position and length; m_last_of_run marks the final token of a byte.
// A byte can close a held identifier, number or slash and emit its own
// token too, so one byte yields zero, one or two result transfers.
// An accepted byte is registered in the input stage, scanned
// combinationally, and its tokens are written into the token queue.
// Throughput: one byte per cycle while the token queue has room; the
// one-token-per-cycle result port holds back bytes that emit two
// tokens. A four-entry token queue sits between scanner and result port.
// When the receiver stalls, the queue fills and s_ready drops once fewer
// than two free entries remain; no token is lost.
// Reset (aresetn low, synchronous) empties the queue and the input stage,
// sets the scanner to idle and clears the byte position.
module c_comment_aware_tokenizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_token_kind,
    output logic [31:0] m_token_start,
    output logic [31:0] m_token_length,
    output logic        m_last_of_run
);

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_byte_reg;
    logic                  room;
    logic                  proc;
    logic                  s_xfer;
    ctat_pkg::token_pair_t tokens;
    ctat_pkg::token_t      out_tok;

    // Input stage: refills in the cycle its byte moves to the scanner
    assign proc    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || proc;
    assign s_xfer  = s_valid && s_ready;

    always_comb begin
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg <= s_text_byte;
        end
    end

    ctat_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (proc),
        .text_byte (in_byte_reg),
        .tokens    (tokens)
    );

    ctat_tokq u_tokq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (proc),
        .tokens    (tokens),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_tok   (out_tok)
    );

    assign m_token_kind   = out_tok.kind;
    assign m_token_start  = out_tok.start;
    assign m_token_length = out_tok.length;
    assign m_last_of_run  = out_tok.last;

endmodule
